FILE: rtl/cllc_pkg.sv
// Shared types and constants for the circular list cursor engine.
package cllc_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int VAL_W    = 32;
	localparam int STEP_W   = 16;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

endpackage

FILE: rtl/circular_list_cursor_engine.sv
// Circular linked list with cursor: link, value and free-stack memories plus a request sequencer.
// Failed requests and those that change no link go from S_IDLE straight to S_OUT; inserts pass
// S_INS (and S_LINK unless the list was empty), removes S_RM_NEXT and S_RM_LINK, and advances
// S_ADV per position, then S_VAL. One request at a time: in_stall is high until S_OUT hands off.
// Reset (arst_n low, asynchronous) empties the list and marks all 256 entries free; a fill mark
// lets untouched free-stack slots read as their reset index, so no clearing pass is needed.
module circular_list_cursor_engine
	import cllc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              op,
	input  logic signed [VAL_W-1:0] value,
	input  logic [STEP_W-1:0]       positions,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] current_value,
	output logic [CNT_W-1:0]        count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_LINK,
		S_RM_NEXT,
		S_RM_LINK,
		S_ADV,
		S_VAL,
		S_OUT
	} state_t;

	state_t  state_q;
	idx_t    cursor_q;
	cnt_t    len_q;
	cnt_t    ftop_q;
	cnt_t    fmark_q;
	val_t    cur_val_q;
	val_t    val_q;
	step_t   steps_q;
	idx_t    pos_q;
	logic    fresh_q;
	idx_t    entry_q;
	status_t res_q;

	idx_t link_mem [CAPACITY];
	val_t val_mem  [CAPACITY];
	idx_t fs_mem   [CAPACITY];

	idx_t link_rd;
	val_t val_rd;
	idx_t fs_rd;

	idx_t link_raddr, link_waddr, link_wdata;
	logic link_we;
	idx_t val_raddr;
	logic val_we;
	idx_t fs_raddr, fs_waddr, fs_wdata;
	logic fs_we;

	cnt_t ftop_m1;
	idx_t new_entry;
	logic in_take;
	logic out_free;
	logic out_load;
	logic fs_room;

	assign ftop_m1   = ftop_q - cnt_t'(1);
	assign new_entry = fresh_q ? (idx_t'(CAPACITY - 1) - pos_q) : fs_rd;
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign out_load  = (state_q == S_OUT) && out_free;
	assign fs_room   = (ftop_q < cnt_t'(CAPACITY));

	always_comb begin
		link_raddr = cursor_q;
		link_we    = 1'b0;
		link_waddr = cursor_q;
		link_wdata = link_rd;
		val_raddr  = link_rd;
		val_we     = 1'b0;
		fs_raddr   = ftop_m1[IDX_W-1:0];
		fs_we      = 1'b0;
		fs_waddr   = ftop_q[IDX_W-1:0];
		fs_wdata   = cursor_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take && op_t'(op) == OP_REMOVE && len_q == cnt_t'(1) && fs_room) begin
					fs_we = 1'b1;
				end
			end
			S_INS: begin
				val_we     = 1'b1;
				link_we    = 1'b1;
				link_waddr = new_entry;
				link_wdata = (len_q == cnt_t'(0)) ? new_entry : link_rd;
			end
			S_LINK: begin
				link_we    = 1'b1;
				link_wdata = entry_q;
			end
			S_RM_NEXT: begin
				link_raddr = link_rd;
			end
			S_RM_LINK: begin
				link_we  = 1'b1;
				fs_we    = fs_room;
				fs_wdata = entry_q;
			end
			S_ADV: begin
				link_raddr = link_rd;
			end
			S_VAL, S_OUT: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rd <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[new_entry] <= val_q;
		end
		val_rd <= val_mem[val_raddr];
	end

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		fs_rd <= fs_mem[fs_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cursor_q      <= '0;
			len_q         <= '0;
			ftop_q        <= cnt_t'(CAPACITY);
			fmark_q       <= cnt_t'(CAPACITY);
			cur_val_q     <= '0;
			val_q         <= '0;
			steps_q       <= '0;
			pos_q         <= '0;
			fresh_q       <= 1'b0;
			entry_q       <= '0;
			res_q         <= ST_OK;
			out_valid     <= 1'b0;
			status        <= '0;
			current_value <= '0;
			count         <= '0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						val_q   <= value;
						steps_q <= positions;
						pos_q   <= ftop_m1[IDX_W-1:0];
						fresh_q <= (ftop_m1 < fmark_q);
						unique case (op_t'(op))
							OP_INSERT: begin
								if (ftop_q == cnt_t'(0)) begin
									res_q   <= ST_FULL;
									state_q <= S_OUT;
								end else begin
									res_q   <= ST_OK;
									state_q <= S_INS;
								end
							end
							OP_REMOVE: begin
								if (len_q == cnt_t'(0)) begin
									res_q   <= ST_INVALID;
									state_q <= S_OUT;
								end else if (len_q == cnt_t'(1)) begin
									res_q   <= ST_OK;
									len_q   <= '0;
									if (fs_room) begin
										ftop_q <= ftop_q + cnt_t'(1);
									end
									state_q <= S_OUT;
								end else begin
									res_q   <= ST_OK;
									state_q <= S_RM_NEXT;
								end
							end
							OP_ADVANCE: begin
								if (len_q == cnt_t'(0)) begin
									res_q   <= ST_INVALID;
									state_q <= S_OUT;
								end else begin
									res_q   <= ST_OK;
									state_q <= (positions != '0) ? S_ADV : S_OUT;
								end
							end
							OP_UNUSED: begin
								res_q   <= ST_INVALID;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_INS: begin
					entry_q   <= new_entry;
					cur_val_q <= val_q;
					ftop_q    <= ftop_m1;
					if (fresh_q) begin
						fmark_q <= ftop_m1;
					end
					if (len_q == cnt_t'(0)) begin
						cursor_q <= new_entry;
						len_q    <= len_q + cnt_t'(1);
						state_q  <= S_OUT;
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					cursor_q <= entry_q;
					len_q    <= len_q + cnt_t'(1);
					state_q  <= S_OUT;
				end
				S_RM_NEXT: begin
					entry_q <= link_rd;
					state_q <= S_RM_LINK;
				end
				S_RM_LINK: begin
					len_q <= len_q - cnt_t'(1);
					if (fs_room) begin
						ftop_q <= ftop_q + cnt_t'(1);
					end
					state_q <= S_OUT;
				end
				S_ADV: begin
					cursor_q <= link_rd;
					steps_q  <= steps_q - step_t'(1);
					if (steps_q == step_t'(1)) begin
						state_q <= S_VAL;
					end
				end
				S_VAL: begin
					cur_val_q <= val_rd;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						status        <= res_q;
						count         <= len_q;
						current_value <= (len_q == cnt_t'(0)) ? '0 : cur_val_q;
						state_q       <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule
